@@ hdl/mawt_pkg.sv @@
// ----------------------------------------------------------------------------
// MAC address whitelist table package
// Sizes, command and status codes, and the transaction structures that are
// shared by the table cells and the top level.
// ----------------------------------------------------------------------------
package mawt_pkg;

    localparam int ENTRIES    = 16;
    localparam int ADDR_BYTES = 8;
    localparam int ADDR_W     = 8 * ADDR_BYTES;
    localparam int IDX_W      = $clog2(ENTRIES);

    localparam int CMD_W      = 3;
    localparam int MAC_W      = 64;
    localparam int LEN_W      = 4;
    localparam int RSSI_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;

    // Input tdata layout, lowest bit first.
    localparam int CMD_LSB    = 0;
    localparam int MAC_LSB    = CMD_LSB + CMD_W;
    localparam int LEN_LSB    = MAC_LSB + MAC_W;
    localparam int RSSI_LSB   = LEN_LSB + LEN_W;
    localparam int IN_BITS    = RSSI_LSB + RSSI_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int STATUS_LSB = 0;
    localparam int HIT_LSB    = STATUS_LSB + STATUS_W;
    localparam int SLOT_LSB   = HIT_LSB + 1;
    localparam int ROUT_LSB   = SLOT_LSB + SLOT_W;
    localparam int OUT_BITS   = ROUT_LSB + RSSI_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND      = 3'd0,
        CMD_ADD       = 3'd1,
        CMD_REMOVE    = 3'd2,
        CMD_CLEAR_ALL = 3'd3,
        CMD_SET_RSSI  = 3'd4,
        CMD_CLR_RSSI  = 3'd5,
        CMD_GET_RSSI  = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NO_RSSI   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_WIPE,
        OP_SET_RSSI,
        OP_CLR_RSSI,
        OP_CLEAR_ALL
    } op_t;

    // Search token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              found;
        logic [IDX_W-1:0]  hit_idx;
        logic              hit_fixed;
        logic [RSSI_W-1:0] hit_rssi;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } tok_t;

    // Update broadcast to every cell once the search has finished.
    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [RSSI_W-1:0] rssi;
    } act_t;

endpackage

@@ hdl/mawt_cell.sv @@
// ----------------------------------------------------------------------------
// MAC address whitelist table cell
// Holds one table entry, compares it with the passing search token and hands
// the updated token to the next cell. Applies broadcast updates to itself.
// ----------------------------------------------------------------------------
module mawt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mawt_pkg::IDX_W-1:0]  cell_idx,
    input  mawt_pkg::tok_t              tok_in,
    output mawt_pkg::tok_t              tok_out,
    input  mawt_pkg::act_t              act
);

    logic                          valid_reg, valid_next;
    logic [mawt_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [mawt_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                          fixed_reg, fixed_next;
    logic [mawt_pkg::RSSI_W-1:0]   rssi_reg, rssi_next;
    mawt_pkg::tok_t                tok_reg, tok_next;
    logic                          match;
    logic                          selected;

    assign match    = valid_reg && (len_reg == tok_in.len) && (addr_reg == tok_in.addr);
    assign selected = (act.idx == cell_idx);

    // The lowest matching and the lowest free cell win, so earlier cells
    // are never overridden.
    always_comb
    begin
        tok_next = tok_in;
        if (match && !tok_in.found)
        begin
            tok_next.found     = 1'b1;
            tok_next.hit_idx   = cell_idx;
            tok_next.hit_fixed = fixed_reg;
            tok_next.hit_rssi  = rssi_reg;
        end
        if (!valid_reg && !tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        fixed_next = fixed_reg;
        rssi_next  = rssi_reg;
        case (act.op)
            mawt_pkg::OP_CLEAR_ALL:
            begin
                valid_next = 1'b0;
            end
            mawt_pkg::OP_ADD:
            begin
                if (selected)
                begin
                    valid_next = 1'b1;
                    addr_next  = act.addr;
                    len_next   = act.len;
                    fixed_next = 1'b0;
                end
            end
            mawt_pkg::OP_WIPE:
            begin
                if (selected)
                begin
                    valid_next = 1'b0;
                    addr_next  = '0;
                    len_next   = '0;
                    fixed_next = 1'b0;
                    rssi_next  = '0;
                end
            end
            mawt_pkg::OP_SET_RSSI:
            begin
                if (selected)
                begin
                    fixed_next = 1'b1;
                    rssi_next  = act.rssi;
                end
            end
            mawt_pkg::OP_CLR_RSSI:
            begin
                if (selected)
                begin
                    fixed_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            addr_reg  <= '0;
            len_reg   <= '0;
            fixed_reg <= 1'b0;
            rssi_reg  <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            fixed_reg <= fixed_next;
            rssi_reg  <= rssi_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ hdl/mac_address_whitelist_table_top.sv @@
// ----------------------------------------------------------------------------
// MAC address whitelist table
// Sixteen-entry address table searched by a token that walks a row of cells.
// ----------------------------------------------------------------------------
// Path: an input transaction is registered in each cell in turn for the search
// walk, then in fin_reg to decide, then in the result registers that offer it
// on the output; loading a result waits while the previous one is not taken.
// A new command is taken only once the previous one has left the cell row and
// its result is loaded, even while the previous result is still held.
// Reset: rst_n clears every entry, the enable flag and all control state.
module mac_address_whitelist_table_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cmd[2:0], mac_addr[66:3], addr_len[70:67], rssi_in[78:71], zero fill
    input  logic [mawt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], hit[2], slot[6:3], rssi_out[14:7], zero fill
    output logic [mawt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic                            filter_enabled_reg;
    mawt_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [mawt_pkg::RSSI_W-1:0]     rssi_reg, rssi_next;
    mawt_pkg::tok_t                  fin_reg, fin_next;
    logic                            out_valid_reg, out_valid_next;
    mawt_pkg::status_t               status_reg, status_next;
    logic                            hit_reg, hit_next;
    logic [mawt_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [mawt_pkg::RSSI_W-1:0]     rout_reg, rout_next;

    logic                            accept;
    logic                            finish;
    mawt_pkg::tok_t                  head_tok;
    mawt_pkg::tok_t                  tok [mawt_pkg::ENTRIES];
    logic [mawt_pkg::ENTRIES-1:0]    tok_vld;
    mawt_pkg::act_t                  act;
    logic [mawt_pkg::MAC_W-1:0]      in_mac;
    logic [mawt_pkg::IDX_W-1:0]      res_idx;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish        = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);
    assign in_mac        = s_axis_tdata[mawt_pkg::MAC_LSB +: mawt_pkg::MAC_W];

    always_comb
    begin
        head_tok       = '0;
        head_tok.valid = accept;
        head_tok.addr  = in_mac[mawt_pkg::ADDR_W-1:0];
        head_tok.len   = s_axis_tdata[mawt_pkg::LEN_LSB +: mawt_pkg::LEN_W];
    end

    for (genvar g = 0; g < mawt_pkg::ENTRIES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            mawt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (mawt_pkg::IDX_W'(g)),
                .tok_in   (head_tok),
                .tok_out  (tok[g]),
                .act      (act)
            );
        end
        else
        begin : g_body
            mawt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (mawt_pkg::IDX_W'(g)),
                .tok_in   (tok[g-1]),
                .tok_out  (tok[g]),
                .act      (act)
            );
        end
        assign tok_vld[g] = tok[g].valid;
    end

    // Decide the result and the table update from the finished search.
    always_comb
    begin
        act         = '0;
        act.op      = mawt_pkg::OP_NONE;
        act.addr    = fin_reg.addr;
        act.len     = fin_reg.len;
        act.rssi    = rssi_reg;
        act.idx     = fin_reg.hit_idx;
        status_next = mawt_pkg::STAT_OK;
        hit_next    = fin_reg.found;
        res_idx     = fin_reg.hit_idx;
        rout_next   = '0;
        case (cmd_reg)
            mawt_pkg::CMD_FIND:
            begin
                if (!fin_reg.found)
                    status_next = mawt_pkg::STAT_NOT_FOUND;
            end
            mawt_pkg::CMD_ADD:
            begin
                if (!fin_reg.found)
                begin
                    if (fin_reg.free_found)
                    begin
                        act.op   = mawt_pkg::OP_ADD;
                        act.idx  = fin_reg.free_idx;
                        hit_next = 1'b1;
                        res_idx  = fin_reg.free_idx;
                    end
                    else
                    begin
                        status_next = mawt_pkg::STAT_FULL;
                    end
                end
            end
            mawt_pkg::CMD_REMOVE:
            begin
                if (fin_reg.found)
                    act.op = mawt_pkg::OP_WIPE;
                else
                    status_next = mawt_pkg::STAT_NOT_FOUND;
            end
            mawt_pkg::CMD_CLEAR_ALL:
            begin
                act.op   = mawt_pkg::OP_CLEAR_ALL;
                hit_next = 1'b0;
            end
            mawt_pkg::CMD_SET_RSSI:
            begin
                if (fin_reg.found)
                    act.op = mawt_pkg::OP_SET_RSSI;
                else
                    status_next = mawt_pkg::STAT_NOT_FOUND;
            end
            mawt_pkg::CMD_CLR_RSSI:
            begin
                if (fin_reg.found)
                    act.op = mawt_pkg::OP_CLR_RSSI;
                else
                    status_next = mawt_pkg::STAT_NOT_FOUND;
            end
            mawt_pkg::CMD_GET_RSSI:
            begin
                if (!fin_reg.found)
                    status_next = mawt_pkg::STAT_NOT_FOUND;
                else if (!fin_reg.hit_fixed)
                    status_next = mawt_pkg::STAT_NO_RSSI;
                else
                    rout_next = fin_reg.hit_rssi;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
        slot_next = hit_next ? mawt_pkg::SLOT_W'(res_idx) : '0;
        // The update reaches the cells only in the cycle the result is loaded.
        if (!finish)
            act.op = mawt_pkg::OP_NONE;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rssi_next      = rssi_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = mawt_pkg::cmd_t'(s_axis_tdata[mawt_pkg::CMD_LSB +:
                                                               mawt_pkg::CMD_W]);
                    rssi_next  = s_axis_tdata[mawt_pkg::RSSI_LSB +: mawt_pkg::RSSI_W];
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tok_vld[mawt_pkg::ENTRIES-1])
                begin
                    fin_next   = tok[mawt_pkg::ENTRIES-1];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            filter_enabled_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
            cmd_reg            <= mawt_pkg::CMD_FIND;
            rssi_reg           <= '0;
            fin_reg            <= '0;
            status_reg         <= mawt_pkg::STAT_OK;
            hit_reg            <= 1'b0;
            slot_reg           <= '0;
            rout_reg           <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            rssi_reg      <= rssi_next;
            fin_reg       <= fin_next;
            if (cfg_wr_en)
                filter_enabled_reg <= cfg_wr_data;
            if (finish)
            begin
                status_reg <= status_next;
                hit_reg    <= hit_next;
                slot_reg   <= slot_next;
                rout_reg   <= rout_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[mawt_pkg::STATUS_LSB +: mawt_pkg::STATUS_W] = status_reg;
        m_axis_tdata[mawt_pkg::HIT_LSB]                        = hit_reg;
        m_axis_tdata[mawt_pkg::SLOT_LSB +: mawt_pkg::SLOT_W]     = slot_reg;
        m_axis_tdata[mawt_pkg::ROUT_LSB +: mawt_pkg::RSSI_W]     = rout_reg;
    end

    // Only one search token may be in the cell row at a time.
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one search token in the cell row");

    // No new command is taken while a search is walking.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_vld != '0) |-> !s_axis_tready)
        else $error("command accepted during a search walk");

    // An accepted command reaches the end of the row after passing every cell register.
    a_walk_length: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(mawt_pkg::ENTRIES) tok_vld[mawt_pkg::ENTRIES-1])
        else $error("search token lost in the cell row");

    // A miss reports slot zero, and a returned rssi comes with an ok hit.
    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((hit_reg || (slot_reg == '0)) &&
                           ((rout_reg == '0) ||
                            (hit_reg && (status_reg == mawt_pkg::STAT_OK)))))
        else $error("inconsistent result fields");

    // The enable flag follows configuration writes only.
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr_en |=> $stable(filter_enabled_reg))
        else $error("enable flag changed without a write");

endmodule
